// ===== sv/wgm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgm_pkg
// Shared types, codes and helpers of the wildcard glob matcher.
// ----------------------------------------------------------------------------
package wgm_pkg;

   // default pattern store depth
   localparam int PATTERN_DEPTH_DEF = 63;

   // entries of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // item operations
   localparam logic [1:0] OP_CLEAR   = 2'd0;
   localparam logic [1:0] OP_APPEND  = 2'd1;
   localparam logic [1:0] OP_SUBJECT = 2'd2;
   localparam logic [1:0] OP_END     = 2'd3;

   // special pattern bytes
   localparam logic [7:0] STAR_CH  = 8'h2A;
   localparam logic [7:0] QMARK_CH = 8'h3F;
   localparam logic [7:0] TAB_CH   = 8'h09;

   // register indexes
   localparam logic [1:0] CSR_ALT_MODE    = 2'd0;
   localparam logic [1:0] CSR_MAX_MATCHES = 2'd1;

   localparam logic [15:0] MAX_MATCHES_RST = 16'hFFFF;

   // classified item handed from front to back
   typedef struct packed {
      logic [1:0] op;
      logic [7:0] fchar;
      logic       is_star;
      logic       is_qmark;
      logic       is_tab;
   } item_type;

   // one result item
   typedef struct packed {
      logic matched;
      logic recorded;
      logic overflow;
   } result_type;

   // register write request
   typedef struct packed {
      logic        valid;
      logic [1:0]  index;
      logic [15:0] data;
   } csr_wr_type;

   // ascii case fold, lower case to upper case
   function automatic logic [7:0] fold_char(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c inside {[8'h61:8'h7A]}) begin
         r = 8'(c - 8'h20);
      end
      return r;
   endfunction

endpackage

// ===== sv/wgm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgm_front
// Input side: takes request transfers and classifies the byte for the back.
// ----------------------------------------------------------------------------
module wgm_front (
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,
   input  logic [1:0]        req_tuser,
   input  logic              q_ready,
   output logic              q_push,
   output wgm_pkg::item_type q_item
);
   import wgm_pkg::*;

   // transfer goes straight into the queue when it has room
   assign req_tready = q_ready;
   assign q_push     = req_tvalid && q_ready;

   // classify the byte once, the back only sees flags and the folded code
   always_comb begin
      q_item.op       = req_tuser;
      q_item.fchar    = fold_char(req_tdata);
      q_item.is_star  = (req_tdata == STAR_CH);
      q_item.is_qmark = (req_tdata == QMARK_CH);
      q_item.is_tab   = (req_tdata == TAB_CH);
   end

endmodule

// ===== sv/wgm_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgm_queue
// Short register queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module wgm_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  wgm_pkg::item_type push_item,
   output logic              in_ready,
   output logic              out_valid,
   output wgm_pkg::item_type head,
   input  logic              pop
);
   import wgm_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   item_type          mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]     wr_ptr_ff;
   logic [PW-1:0]     rd_ptr_ff;
   logic [CW-1:0]     level_ff;
   logic [CW-1:0]     level_in;

   assign in_ready  = (level_ff != CW'(QUEUE_DEPTH));
   assign out_valid = (level_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];

   // fill level follows push and pop
   always_comb begin
      level_in = level_ff;
      if (push && !pop) begin
         level_in = CW'(level_ff + 1'b1);
      end else if (pop && !push) begin
         level_in = CW'(level_ff - 1'b1);
      end
   end

   // pointers, wrapping at the depth
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         level_ff <= level_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(wr_ptr_ff + 1'b1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(rd_ptr_ff + 1'b1);
         end
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== sv/wgm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgm_back
// Match engine: pattern store, active position vector and result register.
// ----------------------------------------------------------------------------
module wgm_back #(
   parameter int PATTERN_DEPTH = wgm_pkg::PATTERN_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  wgm_pkg::csr_wr_type csr_wr,
   input  logic                q_valid,
   input  wgm_pkg::item_type   q_head,
   output logic                q_pop,
   output logic                res_valid,
   input  logic                res_ready,
   output wgm_pkg::result_type res
);
   import wgm_pkg::*;

   localparam int W  = PATTERN_DEPTH + 1;
   localparam int LW = $clog2(PATTERN_DEPTH + 1);
   localparam int IW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;

   // pattern store, each entry compared at its own position
   logic [7:0]               fchar_ff [PATTERN_DEPTH];
   logic [PATTERN_DEPTH-1:0] star_ff;
   logic [PATTERN_DEPTH-1:0] qmark_ff;
   logic [PATTERN_DEPTH-1:0] tab_ff;

   // control state
   logic                     mode_ff;
   logic [15:0]              max_ff;
   logic [LW-1:0]            len_ff;
   logic [15:0]              count_ff;
   logic [15:0]              count_in;
   logic                     overflow_ff;
   logic                     last_tab_ff;
   logic [W-1:0]             active_ff;
   logic [W-1:0]             start0_ff;
   logic [W-1:0]             start1_ff;
   logic                     res_valid_ff;
   logic                     res_valid_in;
   result_type               res_ff;

   // combinational
   logic                     is_end;
   logic [PATTERN_DEPTH-1:0] lt_len;
   logic [PATTERN_DEPTH-1:0] live;
   logic [PATTERN_DEPTH-1:0] hit;
   logic [W-1:0]             next_v;
   logic [W-1:0]             smask;
   logic [W-1:0]             tsel;
   logic [W-1:0]             sum_v;
   logic [W-1:0]             closed_v;
   logic [W-1:0]             len_one;
   logic                     matched_c;
   logic                     rec_c;
   logic                     append_ok;
   logic [LW-1:0]            len_nx;
   logic                     v0_m0;
   logic                     v0_m1;
   logic                     ext_m0;
   logic                     ext_m1;
   logic [W-1:0]             start0_app;
   logic [W-1:0]             start1_app;
   logic [W-1:0]             start_cur;

   // take from the queue unless a result would overwrite a waiting one
   assign is_end = (q_head.op == OP_END);
   assign q_pop  = q_valid && (!is_end || !res_valid_ff || res_ready);

   assign res_valid = res_valid_ff;
   assign res       = res_ff;

   // positions inside the loaded pattern
   always_comb begin
      for (int p = 0; p < PATTERN_DEPTH; p++) begin
         lt_len[p] = (LW'(p) < len_ff);
      end
   end

   // per-position step on one subject byte
   always_comb begin
      for (int p = 0; p < PATTERN_DEPTH; p++) begin
         live[p] = active_ff[p] && lt_len[p] && !(mode_ff && tab_ff[p]);
         hit[p]  = qmark_ff[p] || (fchar_ff[p] == q_head.fchar);
      end
      next_v = {1'b0, live & star_ff} | {live & ~star_ff & hit, 1'b0};
   end

   // star closure as one carry chain: a live star carries through the star run
   always_comb begin
      smask    = {1'b0, star_ff & lt_len};
      tsel     = next_v & smask;
      sum_v    = W'(tsel + smask);
      closed_v = next_v | (sum_v ^ tsel ^ smask);
   end

   // end of subject check
   always_comb begin
      len_one = W'(1) << len_ff;
      if (mode_ff) begin
         matched_c = |(active_ff & ({1'b0, tab_ff & lt_len} | len_one));
      end else begin
         matched_c = |(active_ff & len_one);
      end
      rec_c = matched_c && (count_ff < max_ff);
      count_in = rec_c ? 16'(count_ff + 1'b1) : count_ff;
   end

   // start sets extended by one appended byte, kept for both modes
   always_comb begin
      append_ok  = (len_ff < LW'(PATTERN_DEPTH));
      len_nx     = LW'(len_ff + 1'b1);
      v0_m0      = (len_ff == '0);
      v0_m1      = ((len_ff == '0) || last_tab_ff) && !q_head.is_tab;
      ext_m0     = (start0_ff[len_ff] || v0_m0) && q_head.is_star;
      ext_m1     = (start1_ff[len_ff] || v0_m1) && q_head.is_star;
      start0_app = start0_ff | (W'(v0_m0) << len_ff) | (W'(ext_m0) << len_nx);
      start1_app = start1_ff | (W'(v0_m1) << len_ff) | (W'(ext_m1) << len_nx);
      start_cur  = mode_ff ? start1_ff : start0_ff;
   end

   // result slot: cleared by a transfer, loaded by an end item
   always_comb begin
      res_valid_in = res_valid_ff;
      if (res_ready) begin
         res_valid_in = 1'b0;
      end
      if (q_pop && is_end) begin
         res_valid_in = 1'b1;
      end
   end

   // control state update
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         max_ff       <= MAX_MATCHES_RST;
         len_ff       <= '0;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         last_tab_ff  <= 1'b0;
         active_ff    <= W'(1);
         start0_ff    <= W'(1);
         start1_ff    <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         res_valid_ff <= res_valid_in;
         if (csr_wr.valid) begin
            case (csr_wr.index)
               CSR_ALT_MODE: begin
                  mode_ff   <= csr_wr.data[0];
                  active_ff <= csr_wr.data[0] ? start1_ff : start0_ff;
               end
               CSR_MAX_MATCHES: begin
                  max_ff <= csr_wr.data;
               end
               default: begin
               end
            endcase
         end
         if (q_pop) begin
            case (q_head.op)
               OP_CLEAR: begin
                  len_ff      <= '0;
                  count_ff    <= '0;
                  overflow_ff <= 1'b0;
                  start0_ff   <= W'(1);
                  start1_ff   <= '0;
                  active_ff   <= mode_ff ? '0 : W'(1);
               end
               OP_APPEND: begin
                  if (append_ok) begin
                     len_ff      <= len_nx;
                     start0_ff   <= start0_app;
                     start1_ff   <= start1_app;
                     last_tab_ff <= q_head.is_tab;
                     active_ff   <= mode_ff ? start1_app : start0_app;
                  end else begin
                     overflow_ff <= 1'b1;
                     active_ff   <= start_cur;
                  end
               end
               OP_SUBJECT: begin
                  active_ff <= closed_v;
               end
               OP_END: begin
                  count_ff  <= count_in;
                  active_ff <= start_cur;
               end
               default: begin
               end
            endcase
         end
      end
   end

   // pattern entry write
   always_ff @(posedge clock) begin
      if (q_pop && (q_head.op == OP_APPEND) && append_ok) begin
         fchar_ff[len_ff[IW-1:0]] <= q_head.fchar;
         star_ff[len_ff[IW-1:0]]  <= q_head.is_star;
         qmark_ff[len_ff[IW-1:0]] <= q_head.is_qmark;
         tab_ff[len_ff[IW-1:0]]   <= q_head.is_tab;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (q_pop && is_end) begin
         res_ff.matched  <= matched_c;
         res_ff.recorded <= rec_c;
         res_ff.overflow <= overflow_ff;
      end
   end

endmodule

// ===== sv/wildcard_glob_matcher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_glob_matcher
// Streaming glob matcher with '*', '?' and case-folded literal bytes.
// ----------------------------------------------------------------------------
// Request channel: req_tuser carries the operation (clear, append pattern
// byte, subject byte, end of subject), req_tdata the byte. Only an end of
// subject item gives a response transfer, with matched, recorded and
// pattern_overflow in rsp_tdata. Register writes go over the csr channel,
// which is always ready; register writes must be made while no item is in
// flight, which the block does not enforce. Throughput: one item per cycle,
// every operation, while no end item waits on a held response. The subject
// step updates the whole active position vector at once: parallel byte
// compares per pattern position and a single carry chain for the star
// closure. An end item goes through the queue, then the response register.
// A two-entry queue sits between the input classifier and the match engine,
// and the response sits in an output register: a stalled receiver stops
// an end item at the queue head and all behind it; earlier items flow on.
// Reset clears the pattern length, count and flags, no clearing pass.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher #(
   parameter int PATTERN_DEPTH = wgm_pkg::PATTERN_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [7:0] char_code
   input  logic [1:0]  req_tuser,  // [1:0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // [0] matched, [1] recorded, [2] pattern_overflow
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import wgm_pkg::*;

   logic       q_ready;
   logic       q_push;
   item_type   q_item;
   logic       q_valid;
   item_type   q_head;
   logic       q_pop;
   csr_wr_type csr_wr;
   result_type res;

   // register writes are always taken
   assign csr_ready    = 1'b1;
   assign csr_wr.valid = csr_valid;
   assign csr_wr.index = csr_index;
   assign csr_wr.data  = csr_data;

   wgm_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_ready    (q_ready),
      .q_push     (q_push),
      .q_item     (q_item)
   );

   wgm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .in_ready  (q_ready),
      .out_valid (q_valid),
      .head      (q_head),
      .pop       (q_pop)
   );

   wgm_back #(
      .PATTERN_DEPTH (PATTERN_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_wr    (csr_wr),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .res_valid (rsp_tvalid),
      .res_ready (rsp_tready),
      .res       (res)
   );

   // response packing
   assign rsp_tdata = {5'b0, res.overflow, res.recorded, res.matched};

`ifndef SYNTH
   // a recorded match is always a match
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tdata[1] || rsp_tdata[0]))
      else $error("recorded set without matched");

   // a new response only follows an end item at the queue head
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(q_valid && (q_head.op == OP_END)))
      else $error("response without end item");
`endif

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the wildcard glob matcher. A cycle-free model of
// the matcher tracks pattern, live positions, match count and overflow, and
// predicts the response to each end-of-subject item. Directed cases come
// first, then randomized pattern/subject sequences over several register
// settings, with random gaps on the request side and stalls on the response
// side.
// ----------------------------------------------------------------------------
module testbench;
   import wgm_pkg::*;

   localparam int CLK_PERIOD    = 10;
   localparam int RESET_CYCLES  = 10;
   localparam int SETTLE_CYCLES = 8;
   localparam int TIMEOUT_NS    = 5_000_000;
   localparam int PAT_DEPTH     = PATTERN_DEPTH_DEF;
   localparam int IDLE_PCT      = 19;

   // register indexes with no register behind them
   localparam logic [1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [1:0] CSR_SPARE_HI = 2'd3;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] char_code
   logic [1:0]  req_tuser;   // [1:0] op
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // [0] matched, [1] recorded, [2] pattern_overflow
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [15:0] csr_data;

   // matcher model state
   logic        alt_mode;
   logic [15:0] match_cap;
   logic [7:0]  pat_bytes [0:PAT_DEPTH-1];
   int          pat_len;
   logic [63:0] live;
   logic [15:0] match_cnt;
   logic        ovf_seen;

   result_type  verdict_queue [$];
   int          mismatch_count = 0;
   int          items_sent = 0;
   int          gap_pct = IDLE_PCT;
   int          stall_pct = IDLE_PCT;

   wildcard_glob_matcher u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ------------------------------------------------------------------------
   // matcher model
   // ------------------------------------------------------------------------

   // ascii lower case to upper case
   function automatic logic [7:0] upcase(logic [7:0] c);
      if (c >= 8'h61 && c <= 8'h7A) begin
         return c - 8'h20;
      end
      return c;
   endfunction

   // a live star also makes the position after it live
   function automatic logic [63:0] close_stars(logic [63:0] v);
      for (int p = 0; p < pat_len; p++) begin
         if (v[p] && pat_bytes[p] == STAR_CH) begin
            v[p+1] = 1'b1;
         end
      end
      return v;
   endfunction

   // first position of every non-empty alternative, or position 0
   function automatic logic [63:0] start_positions();
      logic [63:0] v;
      v = '0;
      if (!alt_mode) begin
         v[0] = 1'b1;
      end else begin
         for (int p = 0; p < pat_len; p++) begin
            if ((p == 0 || pat_bytes[p-1] == TAB_CH) && pat_bytes[p] != TAB_CH) begin
               v[p] = 1'b1;
            end
         end
      end
      return close_stars(v);
   endfunction

   // live at the pattern end, or at a separator in alternatives mode
   function automatic logic any_accept(logic [63:0] v);
      if (!alt_mode) begin
         return v[pat_len];
      end
      for (int p = 0; p <= pat_len; p++) begin
         if (v[p] && (p == pat_len || pat_bytes[p] == TAB_CH)) begin
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic void model_reset();
      alt_mode  = 1'b0;
      match_cap = MAX_MATCHES_RST;
      pat_len   = 0;
      match_cnt = '0;
      ovf_seen  = 1'b0;
      for (int i = 0; i < PAT_DEPTH; i++) begin
         pat_bytes[i] = '0;
      end
      live = start_positions();
   endfunction

   function automatic void model_csr_write(logic [1:0] idx, logic [15:0] val);
      case (idx)
         CSR_ALT_MODE: begin
            alt_mode = val[0];
            live     = start_positions();
         end
         CSR_MAX_MATCHES: begin
            match_cap = val;
         end
         default: begin
         end
      endcase
   endfunction

   // advance the model by one accepted item, queue the verdict of an end item
   function automatic void glob_predict(logic [1:0] op, logic [7:0] ch);
      logic [63:0] nxt;
      result_type  v;
      case (op)
         OP_CLEAR: begin
            pat_len   = 0;
            match_cnt = '0;
            ovf_seen  = 1'b0;
            live      = start_positions();
         end
         OP_APPEND: begin
            if (pat_len < PAT_DEPTH) begin
               pat_bytes[pat_len] = ch;
               pat_len++;
            end else begin
               ovf_seen = 1'b1;
            end
            live = start_positions();
         end
         OP_SUBJECT: begin
            nxt = '0;
            for (int p = 0; p < pat_len; p++) begin
               if (live[p] && !(alt_mode && pat_bytes[p] == TAB_CH)) begin
                  if (pat_bytes[p] == STAR_CH) begin
                     nxt[p] = 1'b1;
                  end else if (pat_bytes[p] == QMARK_CH ||
                               upcase(pat_bytes[p]) == upcase(ch)) begin
                     nxt[p+1] = 1'b1;
                  end
               end
            end
            live = close_stars(nxt);
         end
         default: begin
            v.matched  = any_accept(live);
            v.recorded = v.matched && (match_cnt < match_cap);
            v.overflow = ovf_seen;
            if (v.recorded) begin
               match_cnt++;
            end
            verdict_queue.insert(verdict_queue.size(), v);
            live = start_positions();
         end
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // response checking
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : check_verdicts
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (verdict_queue.size() == 0) begin
            $error("response transfer with no verdict pending: tdata=%h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = verdict_queue.pop_front();
            if (rsp_tdata[0] !== want.matched) begin
               $error("matched: expected %b, actual %b", want.matched, rsp_tdata[0]);
               mismatch_count++;
            end
            if (rsp_tdata[1] !== want.recorded) begin
               $error("recorded: expected %b, actual %b", want.recorded, rsp_tdata[1]);
               mismatch_count++;
            end
            if (rsp_tdata[2] !== want.overflow) begin
               $error("pattern_overflow: expected %b, actual %b", want.overflow,
                      rsp_tdata[2]);
               mismatch_count++;
            end
         end
      end
   end

   // receiver stalls at random
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // ------------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------------

   // one request transfer, with random gaps ahead of it
   task automatic send_item(logic [1:0] op, logic [7:0] ch);
      while ($urandom_range(99) < gap_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= ch;
      do @(posedge clock); while (!req_tready);
      glob_predict(op, ch);
      items_sent++;
   endtask

   task automatic write_csr(logic [1:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      model_csr_write(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // stop sending and wait for every pending verdict
   task automatic hold_for_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (verdict_queue.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // block fully idle, including items that give no response
   task automatic quiesce();
      hold_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   function automatic logic [7:0] pick_pattern_byte();
      int r;
      r = $urandom_range(99);
      if (r < 25) return STAR_CH;
      if (r < 40) return QMARK_CH;
      if (r < 50) return TAB_CH;
      if (r < 85) return 8'h41 + 8'($urandom_range(3)) + ($urandom_range(1) ? 8'h20 : 8'h00);
      return 8'($urandom);
   endfunction

   function automatic logic [7:0] pick_subject_byte();
      case ($urandom_range(9))
         0: return 8'h61;
         1: return 8'h42;
         2: return STAR_CH;
         3: return QMARK_CH;
         4: return TAB_CH;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic load_pattern(int len);
      repeat (len) send_item(OP_APPEND, pick_pattern_byte());
   endtask

   // subject built to follow the current pattern, sometimes spoiled
   task automatic run_subject();
      logic [7:0] subj [$];
      int         starts [$];
      int         from;
      logic [7:0] c;
      from = 0;
      if (alt_mode) begin
         for (int p = 0; p < pat_len; p++) begin
            if ((p == 0 || pat_bytes[p-1] == TAB_CH) && pat_bytes[p] != TAB_CH) begin
               starts.insert(starts.size(), p);
            end
         end
         from = (starts.size() == 0) ? pat_len :
                starts[$urandom_range(starts.size() - 1)];
      end
      for (int p = from; p < pat_len; p++) begin
         c = pat_bytes[p];
         if (alt_mode && c == TAB_CH) break;
         if (c == STAR_CH) begin
            repeat ($urandom_range(3)) subj.insert(subj.size(), pick_subject_byte());
         end else if (c == QMARK_CH) begin
            subj.insert(subj.size(), pick_subject_byte());
         end else begin
            if (upcase(c) >= 8'h41 && upcase(c) <= 8'h5A && $urandom_range(1)) begin
               c = c ^ 8'h20;
            end
            subj.insert(subj.size(), c);
         end
      end
      // spoil about a third of the subjects
      if ($urandom_range(99) < 30) begin
         case ($urandom_range(2))
            0: if (subj.size() != 0) subj[$urandom_range(subj.size() - 1)] = pick_subject_byte();
            1: subj.insert($urandom_range(subj.size()), pick_subject_byte());
            default: if (subj.size() != 0) void'(subj.pop_back());
         endcase
      end
      foreach (subj[i]) send_item(OP_SUBJECT, subj[i]);
      send_item(OP_END, 8'($urandom));
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // empty pattern, literals with case folding, star, question, zero and 0xff
   task automatic test_basic();
      send_item(OP_END, 8'hFF);
      send_item(OP_SUBJECT, 8'h71);
      send_item(OP_END, 8'h00);
      send_item(OP_APPEND, 8'h61);
      send_item(OP_APPEND, STAR_CH);
      send_item(OP_APPEND, QMARK_CH);
      send_item(OP_APPEND, 8'h00);
      send_item(OP_APPEND, 8'hFF);
      send_item(OP_SUBJECT, 8'h41);
      send_item(OP_SUBJECT, 8'h78);
      send_item(OP_SUBJECT, 8'h00);
      send_item(OP_SUBJECT, 8'h00);
      send_item(OP_SUBJECT, 8'hFF);
      send_item(OP_END, 8'h5A);
   endtask

   // matches beyond the capacity are reported but not recorded
   task automatic test_capacity();
      quiesce();
      write_csr(CSR_MAX_MATCHES, 16'd1);
      send_item(OP_CLEAR, 8'hA5);
      send_item(OP_END, 8'h00);
      send_item(OP_END, 8'h00);
      quiesce();
      write_csr(CSR_MAX_MATCHES, 16'd0);
      send_item(OP_CLEAR, 8'h00);
      send_item(OP_END, 8'h00);
      quiesce();
      write_csr(CSR_MAX_MATCHES, MAX_MATCHES_RST);
   endtask

   // tab separated alternatives, empty alternatives, restart on mode write
   task automatic test_alternatives();
      quiesce();
      write_csr(CSR_SPARE_LO, 16'hFFFF);
      write_csr(CSR_SPARE_HI, 16'h0000);
      write_csr(CSR_ALT_MODE, 16'h0001);
      send_item(OP_CLEAR, 8'h00);
      send_item(OP_END, 8'h00);
      send_item(OP_APPEND, TAB_CH);
      send_item(OP_APPEND, TAB_CH);
      send_item(OP_END, 8'h00);
      send_item(OP_CLEAR, 8'h00);
      send_item(OP_APPEND, 8'h61);
      send_item(OP_APPEND, TAB_CH);
      send_item(OP_APPEND, TAB_CH);
      send_item(OP_APPEND, 8'h62);
      send_item(OP_APPEND, STAR_CH);
      send_item(OP_SUBJECT, 8'h42);
      send_item(OP_SUBJECT, 8'h7A);
      send_item(OP_END, 8'h00);
      send_item(OP_SUBJECT, 8'h61);
      send_item(OP_END, 8'h00);
      // a mode write in mid subject starts the subject over
      send_item(OP_SUBJECT, 8'h61);
      quiesce();
      write_csr(CSR_ALT_MODE, 16'h0001);
      send_item(OP_END, 8'h00);
      quiesce();
      write_csr(CSR_ALT_MODE, 16'h0000);
   endtask

   // appends past a full store are dropped and flagged until the next clear
   task automatic test_store_overflow();
      send_item(OP_CLEAR, 8'h00);
      send_item(OP_APPEND, STAR_CH);
      load_pattern(PAT_DEPTH + 2);
      run_subject();
      run_subject();
      send_item(OP_CLEAR, 8'hFF);
      send_item(OP_END, 8'h00);
   endtask

   // random pattern and subject sequences under one register setting
   task automatic test_random_phase(logic alt, logic [15:0] cap, int count, bit gaps);
      int          first;
      int          r;
      logic [15:0] mode_word;
      quiesce();
      mode_word    = 16'($urandom);
      mode_word[0] = alt;
      write_csr(CSR_ALT_MODE, mode_word);
      write_csr(CSR_MAX_MATCHES, cap);
      gap_pct   = gaps ? IDLE_PCT : 0;
      stall_pct = gaps ? IDLE_PCT : 0;
      first = items_sent;
      while (items_sent - first < count) begin
         r = $urandom_range(99);
         if (r < 2) begin
            hold_for_results();
         end else if (r < 8) begin
            send_item(2'($urandom), 8'($urandom));
         end else begin
            if ($urandom_range(99) < 40) begin
               send_item(OP_CLEAR, 8'($urandom));
               load_pattern(($urandom_range(9) == 0) ? $urandom_range(40, 70)
                                                    : $urandom_range(0, 8));
            end else if ($urandom_range(99) < 20) begin
               load_pattern($urandom_range(1, 3));
            end
            repeat ($urandom_range(1, 5)) run_subject();
         end
      end
      gap_pct   = IDLE_PCT;
      stall_pct = IDLE_PCT;
   endtask

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------
   initial begin
      model_reset();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_CLEAR;
      rsp_tready = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = CSR_ALT_MODE;
      csr_data   = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_basic();
      test_capacity();
      test_alternatives();
      test_store_overflow();
      test_random_phase(1'b0, MAX_MATCHES_RST, 230, 1'b1);
      test_random_phase(1'b1, 16'd3, 230, 1'b1);
      test_random_phase(1'b0, 16'd0, 230, 1'b0);
      test_random_phase(1'b1, MAX_MATCHES_RST, 230, 1'b1);
      test_random_phase(1'b0, 16'($urandom), 230, 1'b1);
      test_random_phase(1'b1, 16'd1, 230, 1'b1);
      quiesce();

      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(TIMEOUT_NS);
      $display("TEST FAILED");
      $finish;
   end

endmodule
